// ===== hdl/plt_pkg.sv =====
package plt_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COORD_W    = 32;
    localparam int TERM_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT_X  = 3'd0,
        CFG_LIGHT_Y  = 3'd1,
        CFG_LIGHT_Z  = 3'd2,
        CFG_CAMERA_X = 3'd3,
        CFG_CAMERA_Y = 3'd4,
        CFG_CAMERA_Z = 3'd5
    } t_cfg_idx;

    // normalizer: largest magnitude is scaled to [2^NORM_MSB, 2^(NORM_MSB+1))
    localparam int NORM_MSB  = 29;
    localparam int NORM_MW   = 30;
    localparam int ISQ_STEPS = 32;
    localparam int ISQ_W     = 63;
    localparam int SUM_W     = 62;
    localparam int LEN_W     = 31;

    localparam int ATTEN_SCALE = 1000;
    localparam int ATTEN_QBITS = 17;
    localparam int SQUARINGS   = 7;
    localparam logic [TERM_W-1:0] TERM_MAX = '1;

endpackage

// ===== hdl/phong_light_terms.sv =====
// Phong light terms for a point light and camera held in six registers.
// Input channel: one surface hit per beat (hit point, unnormalized normal,
// occlusion flag), taken on i_valid while o_stall is low.
// Output channel: one result per hit, in order, taken on o_valid while
// i_stall is low. An occluded hit returns o_shadowed = 1 and zero terms.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data. The user
// must write them only while no hit is in flight; the block itself does not
// enforce it. Indexes above 5 are dropped. Throughput: one hit per cycle
// while i_stall does not hold the output. The latency is set by two passes
// through the vector normalizer (32 square root stages plus FRAC_BITS+1
// divide stages each) and the 17-stage attenuation divider.
// The whole pipeline advances together; when a result waits on i_stall,
// every stage holds and o_stall goes high, so nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and clears the
// light and camera positions to zero.
module phong_light_terms #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [plt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [plt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [plt_pkg::COORD_W-1:0]  i_hit_x,
    input  logic signed [plt_pkg::COORD_W-1:0]  i_hit_y,
    input  logic signed [plt_pkg::COORD_W-1:0]  i_hit_z,
    input  logic signed [plt_pkg::COORD_W-1:0]  i_surf_nx,
    input  logic signed [plt_pkg::COORD_W-1:0]  i_surf_ny,
    input  logic signed [plt_pkg::COORD_W-1:0]  i_surf_nz,
    input  logic                                i_occluded,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_shadowed,
    output logic [plt_pkg::TERM_W-1:0]          o_diffuse_term,
    output logic [plt_pkg::TERM_W-1:0]          o_specular_term,
    output logic [plt_pkg::TERM_W-1:0]          o_atten_term
);

    localparam int F    = FRAC_BITS;
    localparam int CW   = plt_pkg::COORD_W;
    localparam int DLW  = CW + 1;          // light/camera minus hit
    localparam int UW   = F + 2;           // unit component
    localparam int PPW  = 2 * UW;          // unit product
    localparam int DW2  = 2 * F + 5;       // dot product sum
    localparam int LNW  = F + 4;
    localparam int PRW  = LNW + UW;
    localparam int RW   = F + 5;           // reflection component
    localparam int DSW  = DLW + 1;         // raw distance
    localparam int TMW  = plt_pkg::TERM_W;
    localparam int NUMW = 26 + F;
    localparam int DENW = ((10 + F > DSW) ? 10 + F : DSW) + 1;
    localparam int CMPW = ((NUMW > DENW + 16) ? NUMW : DENW + 16) + 1;
    localparam int QB   = plt_pkg::ATTEN_QBITS;
    localparam int RTW  = 1 + TMW + DSW + 3 * UW;
    localparam logic [NUMW-1:0] ATT_NUM = NUMW'(plt_pkg::ATTEN_SCALE) << (F + 16);
    localparam logic [DENW-1:0] ATT_BASE = DENW'(plt_pkg::ATTEN_SCALE) << F;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // configuration
    logic signed [CW-1:0] r_light [3];
    logic signed [CW-1:0] r_cam   [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                r_light[c] <= '0;
                r_cam[c]   <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                plt_pkg::CFG_LIGHT_X:  r_light[0] <= i_cfg_data;
                plt_pkg::CFG_LIGHT_Y:  r_light[1] <= i_cfg_data;
                plt_pkg::CFG_LIGHT_Z:  r_light[2] <= i_cfg_data;
                plt_pkg::CFG_CAMERA_X: r_cam[0]   <= i_cfg_data;
                plt_pkg::CFG_CAMERA_Y: r_cam[1]   <= i_cfg_data;
                plt_pkg::CFG_CAMERA_Z: r_cam[2]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // T0: vectors toward light and camera
    logic                  r0_v;
    logic                  r0_occ;
    logic signed [DLW-1:0] r0_tl [3];
    logic signed [DLW-1:0] r0_tv [3];
    logic signed [CW-1:0]  r0_n  [3];
    logic signed [CW-1:0]  hit   [3];

    assign hit[0] = i_hit_x;
    assign hit[1] = i_hit_y;
    assign hit[2] = i_hit_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r0_tl[c] <= DLW'(r_light[c]) - DLW'(hit[c]);
                r0_tv[c] <= DLW'(r_cam[c]) - DLW'(hit[c]);
            end
            r0_n[0] <= i_surf_nx;
            r0_n[1] <= i_surf_ny;
            r0_n[2] <= i_surf_nz;
            r0_occ  <= i_occluded;
        end
    end

    // first normalizer pass: L (with distance), V, N
    logic                 nl_v;
    logic [0:0]           nl_occ;
    logic signed [UW-1:0] nl_u [3];
    logic signed [UW-1:0] nv_u [3];
    logic signed [UW-1:0] nn_u [3];
    logic [DSW-1:0]       nl_len;

    plt_norm #(.W(DLW), .F(F), .TW(1)) u_norm_l (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r0_v),
        .i_vx(r0_tl[0]), .i_vy(r0_tl[1]), .i_vz(r0_tl[2]), .i_tag(r0_occ),
        .o_valid(nl_v), .o_ux(nl_u[0]), .o_uy(nl_u[1]), .o_uz(nl_u[2]),
        .o_len(nl_len), .o_tag(nl_occ)
    );

    plt_norm #(.W(DLW), .F(F), .TW(1)) u_norm_v (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r0_v),
        .i_vx(r0_tv[0]), .i_vy(r0_tv[1]), .i_vz(r0_tv[2]), .i_tag(r0_occ),
        .o_valid(), .o_ux(nv_u[0]), .o_uy(nv_u[1]), .o_uz(nv_u[2]),
        .o_len(), .o_tag()
    );

    plt_norm #(.W(CW), .F(F), .TW(1)) u_norm_n (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r0_v),
        .i_vx(r0_n[0]), .i_vy(r0_n[1]), .i_vz(r0_n[2]), .i_tag(r0_occ),
        .o_valid(), .o_ux(nn_u[0]), .o_uy(nn_u[1]), .o_uz(nn_u[2]),
        .o_len(), .o_tag()
    );

    // T1..T5: N.L, diffuse, reflection
    logic                  r1_v, r2_v, r3_v, r4_v, r5_v;
    logic                  r1_occ, r2_occ, r3_occ, r4_occ;
    logic [DSW-1:0]        r1_d, r2_d, r3_d, r4_d;
    logic signed [UW-1:0]  r1_l [3], r2_l [3], r3_l [3], r4_l [3];
    logic signed [UW-1:0]  r1_n [3], r2_n [3], r3_n [3];
    logic signed [UW-1:0]  r1_vv [3], r2_vv [3], r3_vv [3], r4_vv [3];
    logic signed [PPW-1:0] r1_p [3];
    logic signed [DW2-1:0] r2_d2;
    logic [TMW-1:0]        r3_diff, r4_diff;
    logic signed [LNW-1:0] r3_ln;
    logic signed [PRW-1:0] r4_pr [3];
    logic signed [RW-1:0]  r5_r [3];
    logic [RTW-1:0]        r5_tag;

    logic [DW2-1:0]        diff_sh;
    logic [TMW-1:0]        diff_c;
    logic signed [DW2-1:0] ln_b;
    logic signed [PRW:0]   p2 [3];
    logic signed [PRW:0]   p2b [3];
    logic signed [RW-1:0]  refl [3];

    always_comb begin
        diff_sh = DW2'($unsigned(r2_d2) >> (2 * F - 16));
        if (r2_d2 <= 0)
            diff_c = '0;
        else if (diff_sh > DW2'(plt_pkg::TERM_MAX))
            diff_c = plt_pkg::TERM_MAX;
        else
            diff_c = diff_sh[TMW-1:0];
        // toward zero
        ln_b = r2_d2 + (r2_d2[DW2-1] ? DW2'((1 << F) - 1) : DW2'(0));
        for (int c = 0; c < 3; c++) begin
            p2[c]   = {r4_pr[c], 1'b0};
            p2b[c]  = p2[c] + (p2[c][PRW] ? (PRW+1)'((1 << F) - 1) : (PRW+1)'(0));
            refl[c] = RW'(p2b[c] >>> F) - RW'(r4_l[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (en) begin
            r1_v <= nl_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r1_p[c]  <= nn_u[c] * nl_u[c];
                r1_l[c]  <= nl_u[c];
                r1_n[c]  <= nn_u[c];
                r1_vv[c] <= nv_u[c];
                r2_l[c]  <= r1_l[c];
                r2_n[c]  <= r1_n[c];
                r2_vv[c] <= r1_vv[c];
                r3_l[c]  <= r2_l[c];
                r3_n[c]  <= r2_n[c];
                r3_vv[c] <= r2_vv[c];
                r4_pr[c] <= r3_ln * r3_n[c];
                r4_l[c]  <= r3_l[c];
                r4_vv[c] <= r3_vv[c];
                r5_r[c]  <= refl[c];
            end
            r1_occ  <= nl_occ[0];
            r1_d    <= nl_len;
            r2_d2   <= DW2'(r1_p[0]) + DW2'(r1_p[1]) + DW2'(r1_p[2]);
            r2_occ  <= r1_occ;
            r2_d    <= r1_d;
            r3_diff <= diff_c;
            r3_ln   <= LNW'(ln_b >>> F);
            r3_occ  <= r2_occ;
            r3_d    <= r2_d;
            r4_diff <= r3_diff;
            r4_occ  <= r3_occ;
            r4_d    <= r3_d;
            r5_tag  <= {r4_occ, r4_diff, r4_d, r4_vv[2], r4_vv[1], r4_vv[0]};
        end
    end

    // second normalizer pass: reflection
    logic                 nr_v;
    logic signed [UW-1:0] nr_u [3];
    logic [RTW-1:0]       nr_tag;
    logic signed [UW-1:0] tv [3];

    plt_norm #(.W(RW), .F(F), .TW(RTW)) u_norm_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r5_v),
        .i_vx(r5_r[0]), .i_vy(r5_r[1]), .i_vz(r5_r[2]), .i_tag(r5_tag),
        .o_valid(nr_v), .o_ux(nr_u[0]), .o_uy(nr_u[1]), .o_uz(nr_u[2]),
        .o_len(), .o_tag(nr_tag)
    );

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            tv[c] = nr_tag[c*UW +: UW];
        end
    end

    // T6: R.V products and attenuation denominator
    logic                  r6_v, r7_v;
    logic                  r6_occ, r7_occ;
    logic [TMW-1:0]        r6_diff, r7_diff;
    logic signed [PPW-1:0] r6_p [3];
    logic [DENW-1:0]       r6_den, r7_den;
    logic [NUMW-1:0]       r7_rem;
    logic [F:0]            r7_s;
    logic signed [DW2-1:0] rv;
    logic [DW2-1:0]        rv_sh;
    logic [F:0]            s_c;

    always_comb begin
        rv    = DW2'(r6_p[0]) + DW2'(r6_p[1]) + DW2'(r6_p[2]);
        rv_sh = DW2'(rv >>> F);
        if (rv <= 0)
            s_c = '0;
        else if (rv_sh > DW2'(ONE))
            s_c = ONE;
        else
            s_c = rv_sh[F:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (en) begin
            r6_v <= nr_v;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r6_p[c] <= nr_u[c] * tv[c];
            end
            r6_den  <= ATT_BASE + DENW'(nr_tag[3*UW +: DSW]);
            r6_diff <= nr_tag[3*UW+DSW +: TMW];
            r6_occ  <= nr_tag[RTW-1];
            r7_s    <= s_c;
            r7_rem  <= ATT_NUM;
            r7_den  <= r6_den;
            r7_diff <= r6_diff;
            r7_occ  <= r6_occ;
        end
    end

    // tail: one attenuation quotient bit per stage, squarings in the first few
    logic              r_tv   [0:QB];
    logic              r_tocc [0:QB];
    logic [TMW-1:0]    r_tdif [0:QB];
    logic [F:0]        r_ts   [0:QB];
    logic [NUMW-1:0]   r_trem [0:QB];
    logic [DENW-1:0]   r_tden [0:QB];
    logic [QB-1:0]     r_tq   [0:QB];

    assign r_tv[0]   = r7_v;
    assign r_tocc[0] = r7_occ;
    assign r_tdif[0] = r7_diff;
    assign r_ts[0]   = r7_s;
    assign r_trem[0] = r7_rem;
    assign r_tden[0] = r7_den;
    assign r_tq[0]   = '0;

    genvar k;
    generate
        for (k = 0; k < QB; k++) begin : g_tail
            logic [CMPW-1:0]  dsh;
            logic             ge;
            logic [2*F+1:0]   sq;
            assign dsh = CMPW'(r_tden[k]) << (QB - 1 - k);
            assign ge  = CMPW'(r_trem[k]) >= dsh;
            assign sq  = r_ts[k] * r_ts[k];
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_tv[k+1] <= 1'b0;
                end else if (en) begin
                    r_tv[k+1] <= r_tv[k];
                end
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_tocc[k+1] <= r_tocc[k];
                    r_tdif[k+1] <= r_tdif[k];
                    r_tden[k+1] <= r_tden[k];
                    r_trem[k+1] <= ge ? NUMW'(CMPW'(r_trem[k]) - dsh) : r_trem[k];
                    r_tq[k+1]   <= {r_tq[k][QB-2:0], ge};
                    if (k < plt_pkg::SQUARINGS)
                        r_ts[k+1] <= (F+1)'(sq >> F);
                    else
                        r_ts[k+1] <= r_ts[k];
                end
            end
        end
    endgenerate

    // output register
    logic            r_ov;
    logic            r_osh;
    logic [TMW-1:0]  r_odif, r_ospec, r_oatt;
    logic [F+16:0]   spec_w;
    logic [TMW-1:0]  spec_c, att_c;

    always_comb begin
        spec_w = ((F+17)'(r_ts[QB]) << 16) >> F;
        spec_c = (spec_w > (F+17)'(plt_pkg::TERM_MAX)) ? plt_pkg::TERM_MAX
                                                       : spec_w[TMW-1:0];
        att_c  = (r_tq[QB] > QB'(plt_pkg::TERM_MAX)) ? plt_pkg::TERM_MAX
                                                     : r_tq[QB][TMW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_tv[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_osh   <= r_tocc[QB];
            r_odif  <= r_tocc[QB] ? '0 : r_tdif[QB];
            r_ospec <= r_tocc[QB] ? '0 : spec_c;
            r_oatt  <= r_tocc[QB] ? '0 : att_c;
        end
    end

    assign o_valid         = r_ov;
    assign o_shadowed      = r_osh;
    assign o_diffuse_term  = r_odif;
    assign o_specular_term = r_ospec;
    assign o_atten_term    = r_oatt;

endmodule

// ===== hdl/plt_norm.sv =====
module plt_norm #(
    parameter int W  = 33,
    parameter int F  = 16,
    parameter int TW = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_vx,
    input  logic signed [W-1:0] i_vy,
    input  logic signed [W-1:0] i_vz,
    input  logic [TW-1:0]       i_tag,
    output logic                o_valid,
    output logic signed [F+1:0] o_ux,
    output logic signed [F+1:0] o_uy,
    output logic signed [F+1:0] o_uz,
    output logic [W:0]          o_len,
    output logic [TW-1:0]       o_tag
);

    localparam int PW   = $clog2(W);
    localparam int SHW  = $clog2(W + 30) + 1;
    localparam int XW   = (W > 30) ? W : 30;
    localparam int LXW  = (W + 1 > 31) ? W + 1 : 31;
    localparam int SDW  = 94 + SHW + TW;
    localparam int T    = 35 + F;
    localparam int NMW  = plt_pkg::NORM_MW;

    // stage 0: magnitudes and signs
    logic                r0_v;
    logic [W-1:0]        r0_m [3];
    logic [2:0]          r0_s;
    logic [TW-1:0]       r0_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_m[0] <= i_vx[W-1] ? W'(-i_vx) : W'(i_vx);
            r0_m[1] <= i_vy[W-1] ? W'(-i_vy) : W'(i_vy);
            r0_m[2] <= i_vz[W-1] ? W'(-i_vz) : W'(i_vz);
            r0_s    <= {i_vz[W-1], i_vy[W-1], i_vx[W-1]};
            r0_tag  <= i_tag;
        end
    end

    // stage 1: leading one of the largest magnitude
    logic [W-1:0]  orv;
    logic [PW-1:0] lead;
    logic          r1_v;
    logic [W-1:0]  r1_m [3];
    logic [2:0]    r1_s;
    logic          r1_z;
    logic [PW-1:0] r1_p;
    logic [TW-1:0] r1_tag;

    always_comb begin
        orv  = r0_m[0] | r0_m[1] | r0_m[2];
        lead = '0;
        for (int b = 0; b < W; b++) begin
            if (orv[b]) lead = PW'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_m   <= r0_m;
            r1_s   <= r0_s;
            r1_z   <= (orv == '0);
            r1_p   <= lead;
            r1_tag <= r0_tag;
        end
    end

    // stage 2: scale to the fixed range, then everything rides in the side bundle
    logic [SDW-1:0]  r_side [0:T];
    logic            r_vld  [0:T];
    logic [NMW-1:0]  nm2 [3];
    logic signed [SHW-1:0] sh2;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (int'(r1_p) >= plt_pkg::NORM_MSB)
                nm2[c] = NMW'(XW'(r1_m[c]) >> (int'(r1_p) - plt_pkg::NORM_MSB));
            else
                nm2[c] = NMW'(XW'(r1_m[c]) << (plt_pkg::NORM_MSB - int'(r1_p)));
        end
        sh2 = SHW'(int'(r1_p) - plt_pkg::NORM_MSB);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= {r1_tag, r1_s, r1_z, sh2, nm2[2], nm2[1], nm2[0]};
        end
    end

    genvar t;
    generate
        for (t = 1; t <= T; t++) begin : g_side
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[t] <= 1'b0;
                end else if (i_en) begin
                    r_vld[t] <= r_vld[t-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_side[t] <= r_side[t-1];
                end
            end
        end
    endgenerate

    // stage 3: squares, stage 4: sum
    logic [2*NMW-1:0] r3_sq [3];
    logic [plt_pkg::SUM_W-1:0] r_n   [0:plt_pkg::ISQ_STEPS];
    logic [plt_pkg::ISQ_W-1:0] r_res [0:plt_pkg::ISQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r3_sq[c] <= r_side[0][c*NMW +: NMW] * r_side[0][c*NMW +: NMW];
            end
            r_n[0]   <= plt_pkg::SUM_W'(r3_sq[0]) + plt_pkg::SUM_W'(r3_sq[1])
                      + plt_pkg::SUM_W'(r3_sq[2]);
            r_res[0] <= '0;
        end
    end

    // integer square root, one result bit per stage
    genvar i;
    generate
        for (i = 0; i < plt_pkg::ISQ_STEPS; i++) begin : g_isq
            localparam logic [plt_pkg::ISQ_W-1:0] BIT =
                plt_pkg::ISQ_W'(1) << (62 - 2 * i);
            logic [plt_pkg::ISQ_W-1:0] trial;
            assign trial = r_res[i] + BIT;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (plt_pkg::ISQ_W'(r_n[i]) >= trial) begin
                        r_n[i+1]   <= plt_pkg::SUM_W'(plt_pkg::ISQ_W'(r_n[i]) - trial);
                        r_res[i+1] <= (r_res[i] >> 1) + BIT;
                    end else begin
                        r_n[i+1]   <= r_n[i];
                        r_res[i+1] <= r_res[i] >> 1;
                    end
                end
            end
        end
    endgenerate

    // unit components: (nm << F) / len, one quotient bit per stage
    logic [31:0]                 r_r   [1:F+1][3];
    logic [F:0]                  r_q   [1:F+1][3];
    logic [plt_pkg::LEN_W-1:0]   r_len [1:F+1];

    genvar k;
    generate
        for (k = 0; k <= F; k++) begin : g_div
            logic [31:0]               rin [3];
            logic [F:0]                qin [3];
            logic [plt_pkg::LEN_W-1:0] lin;
            logic [31:0]               rem [3];
            logic                      ge  [3];
            if (k == 0) begin : g_i0
                always_comb begin
                    for (int c = 0; c < 3; c++) begin
                        rin[c] = 32'(r_side[34][c*NMW +: NMW]);
                        qin[c] = '0;
                    end
                end
                assign lin = r_res[plt_pkg::ISQ_STEPS][plt_pkg::LEN_W-1:0];
            end else begin : g_in
                always_comb begin
                    for (int c = 0; c < 3; c++) begin
                        rin[c] = r_r[k][c];
                        qin[c] = r_q[k][c];
                    end
                end
                assign lin = r_len[k];
            end
            always_comb begin
                for (int c = 0; c < 3; c++) begin
                    ge[c]  = rin[c] >= 32'(lin);
                    rem[c] = ge[c] ? rin[c] - 32'(lin) : rin[c];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    for (int c = 0; c < 3; c++) begin
                        r_r[k+1][c] <= rem[c] << 1;
                        r_q[k+1][c] <= {qin[c][F-1:0], ge[c]};
                    end
                    r_len[k+1] <= lin;
                end
            end
        end
    endgenerate

    // output: sign back on, raw length rescaled
    logic [TW-1:0]         tag_o;
    logic [2:0]            sgn_o;
    logic                  z_o;
    logic signed [SHW-1:0] sh_o;
    logic [LXW-1:0]        len_x;
    logic signed [F+1:0]   u [3];

    always_comb begin
        tag_o = r_side[T][94+SHW +: TW];
        sgn_o = r_side[T][91+SHW +: 3];
        z_o   = r_side[T][90+SHW];
        sh_o  = r_side[T][90 +: SHW];
        if (sh_o >= 0)
            len_x = LXW'(r_len[F+1]) << int'(sh_o);
        else
            len_x = LXW'(r_len[F+1]) >> int'(-sh_o);
        for (int c = 0; c < 3; c++) begin
            if (z_o)
                u[c] = '0;
            else if (sgn_o[c])
                u[c] = -$signed({1'b0, r_q[F+1][c]});
            else
                u[c] = $signed({1'b0, r_q[F+1][c]});
        end
    end

    assign o_valid = r_vld[T];
    assign o_ux    = u[0];
    assign o_uy    = u[1];
    assign o_uz    = u[2];
    assign o_len   = z_o ? '0 : len_x[W:0];
    assign o_tag   = tag_o;

endmodule
